// ----- hdl/ggr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggr_pkg
// Shared widths, register indexes and constants of the 3x3 pyramid reducer.
// ----------------------------------------------------------------------------
package ggr_pkg;

  localparam int PIX_W  = 8;   // gray pixel
  localparam int VSUM_W = 10;  // vertical 1-2-1 sum, at most 1020
  localparam int SUM_W  = 13;  // full 3x3 sum plus rounding bias
  localparam int HGT_W  = 16;  // image height / row counter
  localparam int CFGW_W = 12;  // image width register
  localparam int CIDX_W = 2;   // config register index
  localparam int CDAT_W = 16;  // config write data

  // smallest usable width, reads and writes of the line store never collide
  localparam int MIN_WIDTH = 16;

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ROUND_ENABLE = 2'd2;

  localparam int RST_IMAGE_WIDTH = 640;
  localparam logic [HGT_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

  localparam logic [SUM_W-1:0] ROUND_BIAS = 13'h0008;

endpackage

// ----- hdl/ggr_line_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggr_line_mem
// Two source-row line stores sharing one read and one write address.
// Read data is registered and holds while rd_en is low.
// ----------------------------------------------------------------------------
module ggr_line_mem #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = 11
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [ggr_pkg::PIX_W-1:0] rd_one,
  output logic [ggr_pkg::PIX_W-1:0] rd_two,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [ggr_pkg::PIX_W-1:0] wr_one,
  input  logic [ggr_pkg::PIX_W-1:0] wr_two
);
  import ggr_pkg::*;

  logic [PIX_W-1:0] line_one_r [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_r [MAX_WIDTH];
  logic [PIX_W-1:0] rd_one_r;
  logic [PIX_W-1:0] rd_two_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_one_r[wr_addr] <= wr_one;
      line_two_r[wr_addr] <= wr_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_one_r <= line_one_r[rd_addr];
      rd_two_r <= line_two_r[rd_addr];
    end
  end

  assign rd_one = rd_one_r;
  assign rd_two = rd_two_r;

endmodule

// ----- hdl/gray_gaussian_reduce_3x3_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_gaussian_reduce_3x3_core
// 2:1 pyramid reduction of a gray raster stream with a 1-2-1 x 1-2-1 kernel,
// edge replication and odd size handling.
// ----------------------------------------------------------------------------
//
// Channel | Ports                          | Contents
// --------+--------------------------------+---------------------------------
// in      | in_tvalid/in_tready/in_tdata   | source pixel, raster order
// out     | out_tvalid/out_tready/out_*    | reduced pixel, row end, frame end
// cfg     | cfg_valid/cfg_ready/cfg_index  | width, height, round enable
//
// One source pixel per clock is accepted while the output is not stalled; a
// result is presented when the output register loads it from stage 1, after
// the transfer of the pixel that completes its window (the line store read
// and the stage 1 register share the transfer edge). The line store's single
// read and single write port per cycle set that rate.
// Reset clears counters, column sums and valids; the line store is not
// cleared and needs no sweep. A stalled output holds stage 1; the input is
// still taken while the output register drains in the same cycle.
// ----------------------------------------------------------------------------
module gray_gaussian_reduce_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] pixel_in
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] pixel_out
  output logic                         out_tlast,  // row_end
  output logic                         out_tuser,  // [0] frame_end
  // config writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ggr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ggr_pkg::CDAT_W-1:0]   cfg_data
);
  import ggr_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);       // column / line store address
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int CW = ((WW > CFGW_W) ? WW : CFGW_W) + 1;
  localparam int RST_W = (RST_IMAGE_WIDTH < MIN_WIDTH) ? MIN_WIDTH :
                         (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;

  typedef struct packed {
    logic q_odd;
    logic q_one;
    logic q_zero;
    logic q_last;
    logic x_odd;
    logic x_one;
    logic x_zero;
    logic x_last;
    logic rend;
    logic fend;
  } pos_t;

  // ---------------- configuration ----------------
  logic [WW-1:0]    w_eff_r;
  logic [HGT_W-1:0] h_eff_r;
  logic             round_r;
  logic [CW-1:0]    cfg_w_ext;
  logic [WW-1:0]    cfg_w_clamp;

  assign cfg_ready = 1'b1;
  assign cfg_w_ext = CW'(cfg_data[CFGW_W-1:0]);

  always_comb begin
    if (cfg_w_ext < CW'(MIN_WIDTH)) begin
      cfg_w_clamp = WW'(MIN_WIDTH);
    end else if (cfg_w_ext > CW'(MAX_WIDTH)) begin
      cfg_w_clamp = WW'(MAX_WIDTH);
    end else begin
      cfg_w_clamp = cfg_w_ext[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= WW'(RST_W);
      h_eff_r <= RST_IMAGE_HEIGHT;
      round_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  w_eff_r <= cfg_w_clamp;
        CFG_IMAGE_HEIGHT: h_eff_r <= (cfg_data == '0) ? HGT_W'(1) : cfg_data;
        CFG_ROUND_ENABLE: round_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: position of the incoming pixel ----------------
  logic [XW-1:0]    col_r, col_nxt;
  logic [HGT_W-1:0] row_r, row_nxt;
  logic             in_fire;
  logic             wrap0;
  logic [HGT_W:0]   row_pre;
  logic [XW-1:0]    x0;
  logic [HGT_W-1:0] q0;
  logic [WW-1:0]    x0_inc;
  logic [HGT_W:0]   q0_inc;
  logic [XW-1:0]    outcol0;
  logic [HGT_W-1:0] outrow0;
  pos_t             pos0;

  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    wrap0   = (WW'(col_r) >= w_eff_r);
    x0      = wrap0 ? '0 : col_r;
    row_pre = wrap0 ? ({1'b0, row_r} + 1'b1) : {1'b0, row_r};
    q0      = (row_pre >= {1'b0, h_eff_r}) ? '0 : row_pre[HGT_W-1:0];
    x0_inc  = WW'(x0) + 1'b1;
    q0_inc  = {1'b0, q0} + 1'b1;
    outcol0 = {x0[XW-1:1], 1'b0};
    outrow0 = {q0[HGT_W-1:1], 1'b0};

    pos0.q_odd  = q0[0];
    pos0.q_one  = (q0 == HGT_W'(1));
    pos0.q_zero = (q0 == '0);
    pos0.q_last = (q0_inc == {1'b0, h_eff_r});
    pos0.x_odd  = x0[0];
    pos0.x_one  = (x0 == XW'(1));
    pos0.x_zero = (x0 == '0);
    pos0.x_last = (x0_inc == w_eff_r);
    // last result of an output row / frame
    pos0.rend   = ((WW'(outcol0) + WW'(2)) >= w_eff_r);
    pos0.fend   = pos0.rend && (({1'b0, outrow0} + 2'd2) >= {1'b0, h_eff_r});

    if (pos0.x_last) begin
      col_nxt = '0;
      row_nxt = (q0_inc >= {1'b0, h_eff_r}) ? '0 : q0_inc[HGT_W-1:0];
    end else begin
      col_nxt = x0_inc[XW-1:0];
      row_nxt = q0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: line store data, vertical and horizontal sums ---
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [XW-1:0]    s1_x_r;
  pos_t             s1_pos_r;
  logic             out_free;
  logic             s1_adv;
  logic [PIX_W-1:0] mem_one;
  logic [PIX_W-1:0] mem_two;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= in_tdata;
      s1_x_r   <= x0;
      s1_pos_r <= pos0;
    end
  end

  ggr_line_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (XW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (x0),
    .rd_one  (mem_one),
    .rd_two  (mem_two),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_one  (s1_pix_r),
    .wr_two  (mem_one)
  );

  logic [VSUM_W-1:0] vp_r, vbp_r;
  logic [PIX_W-1:0]  v_top, v_mid, v_bot;
  logic              row_done;
  logic [VSUM_W-1:0] v1;
  logic [VSUM_W-1:0] h_left, h_mid;
  logic              emit1;
  logic [SUM_W-1:0]  sum1;

  always_comb begin
    // vertical 1-2-1, top row replicated at frame top, bottom at frame end
    if (s1_pos_r.q_odd) begin
      v_mid    = mem_one;
      v_top    = s1_pos_r.q_one ? mem_one : mem_two;
      v_bot    = s1_pix_r;
      row_done = 1'b1;
    end else if (s1_pos_r.q_last) begin
      v_mid    = s1_pix_r;
      v_top    = s1_pos_r.q_zero ? s1_pix_r : mem_one;
      v_bot    = s1_pix_r;
      row_done = 1'b1;
    end else begin
      v_mid    = '0;
      v_top    = '0;
      v_bot    = '0;
      row_done = 1'b0;
    end
    v1 = VSUM_W'(v_top) + {1'b0, v_mid, 1'b0} + VSUM_W'(v_bot);

    // horizontal 1-2-1 over vertical sums, left column replicated
    emit1 = row_done && (s1_pos_r.x_odd || s1_pos_r.x_last);
    if (s1_pos_r.x_odd) begin
      h_left = s1_pos_r.x_one ? vp_r : vbp_r;
      h_mid  = vp_r;
    end else begin
      h_left = s1_pos_r.x_zero ? v1 : vp_r;
      h_mid  = v1;
    end
    sum1 = SUM_W'(h_left) + SUM_W'({h_mid, 1'b0}) + SUM_W'(v1);
    if (round_r) begin
      sum1 = sum1 + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r  <= '0;
      vbp_r <= '0;
    end else if (s1_adv) begin
      if (s1_pos_r.x_last) begin
        vp_r  <= '0;
        vbp_r <= '0;
      end else begin
        vbp_r <= vp_r;
        vp_r  <= v1;
      end
    end
  end

  // ---------------- output register ----------------
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_rend_r;
  logic             out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pix_r  <= sum1[PIX_W+3:4];
      out_rend_r <= s1_pos_r.rend;
      out_fend_r <= s1_pos_r.fend;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_rend_r;
  assign out_tuser  = out_fend_r;

  // ---------------- checks ----------------
  // frame end only ever lands on a row end
  a_fend_on_rend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rend_r || !out_fend_r))
    else $error("frame end without row end");

  // a pixel is never taken while stage 1 is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_valid_r || s1_adv))
    else $error("stage 1 overrun");

  // read and write of the line store never hit the same entry in one cycle
  a_mem_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_adv) |-> (x0 != s1_x_r))
    else $error("line store read/write collision");

  // column sums restart at each row
  a_vsum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_pos_r.x_last) |=> (vp_r == '0 && vbp_r == '0))
    else $error("column sums not cleared at row end");

endmodule

// ----- verif/ggr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggr_checker
// Watches the pixel, result and register channels of the pyramid reducer,
// keeps its own copy of the line rows, counters and column sums, and compares
// every result transfer with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module ggr_checker
  import ggr_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [PIX_W-1:0]    in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [PIX_W-1:0]    out_tdata,
  input  logic                out_tlast,
  input  logic                out_tuser,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDAT_W-1:0]   cfg_data,
  output int                  errors,
  output int                  pending
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } reduced_px_t;

  reduced_px_t due_pixels[$];

  logic [CFGW_W-1:0] reg_width;
  logic [HGT_W-1:0]  reg_height;
  logic              reg_round;

  logic [PIX_W-1:0]  row_two_up [MAX_WIDTH];
  logic [PIX_W-1:0]  row_one_up [MAX_WIDTH];
  int unsigned       col, row;
  logic [VSUM_W-1:0] vsum_p1, vsum_p2;

  // one source pixel in: 1-2-1 vertically over the column, then 1-2-1 across
  // the last three column sums; at most one reduced pixel comes out
  task automatic reduce_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h, x, q, top, mid, bot, lft, ctr, rgt, sum, ocol, orow;
    logic [VSUM_W-1:0] v;
    bit vdone, fire;
    reduced_px_t px;
    w = (reg_width < MIN_WIDTH) ? MIN_WIDTH :
        (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
    h = (reg_height == 0) ? 1 : reg_height;
    // shrunk sizes wrap the position first
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    x = col;
    q = row;
    top = 0; mid = 0; bot = 0; vdone = 0; fire = 0;
    lft = 0; ctr = 0; rgt = 0; ocol = 0;
    if (q & 1) begin
      mid = row_one_up[x];
      top = (q == 1) ? mid : row_two_up[x];
      bot = pix;
      vdone = 1;
    end else if (q == h - 1) begin
      // bottom row of odd height: replicate downward
      mid = pix;
      top = (q == 0) ? pix : row_one_up[x];
      bot = pix;
      vdone = 1;
    end
    v = VSUM_W'(top + 2 * mid + bot);
    if (vdone) begin
      if (x & 1) begin
        lft  = (x == 1) ? vsum_p1 : vsum_p2;
        ctr  = vsum_p1;
        rgt  = v;
        ocol = x - 1;
        fire = 1;
      end else if (x == w - 1) begin
        lft  = (x == 0) ? v : vsum_p1;
        ctr  = v;
        rgt  = v;
        ocol = x;
        fire = 1;
      end
    end
    if (fire) begin
      orow = (q & 1) ? q - 1 : q;
      sum  = lft + 2 * ctr + rgt;
      if (reg_round) sum += ROUND_BIAS;
      px.pix       = PIX_W'(sum >> 4);
      px.row_end   = (ocol + 2 >= w);
      px.frame_end = px.row_end && (orow + 2 >= h);
      due_pixels.push_back(px);
    end
    vsum_p2       = vsum_p1;
    vsum_p1       = v;
    row_two_up[x] = row_one_up[x];
    row_one_up[x] = pix;
    col = x + 1;
    if (col >= w) begin
      col = 0;
      row = q + 1;
      if (row >= h) row = 0;
      vsum_p1 = '0;
      vsum_p2 = '0;
    end
  endtask

  task automatic check_result();
    reduced_px_t want;
    if (due_pixels.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, got pix %0d rend %0b fend %0b",
               $time, out_tdata, out_tlast, out_tuser);
    end else begin
      want = due_pixels.pop_front();
      if (want.pix !== out_tdata || want.row_end !== out_tlast ||
          want.frame_end !== out_tuser) begin
        errors++;
        $display("%0t: expected pix %0d rend %0b fend %0b, actual pix %0d rend %0b fend %0b",
                 $time, want.pix, want.row_end, want.frame_end,
                 out_tdata, out_tlast, out_tuser);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_width  = CFGW_W'(RST_IMAGE_WIDTH);
      reg_height = RST_IMAGE_HEIGHT;
      reg_round  = 1'b0;
      col        = 0;
      row        = 0;
      vsum_p1    = '0;
      vsum_p2    = '0;
      errors     = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_two_up[i] = '0;
        row_one_up[i] = '0;
      end
      due_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  reg_width  = cfg_data[CFGW_W-1:0];
          CFG_IMAGE_HEIGHT: reg_height = cfg_data[HGT_W-1:0];
          CFG_ROUND_ENABLE: reg_round  = cfg_data[0];
          default: ;
        endcase
      end
      // results leave through registers after their pixel is taken, so compare before predicting
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) reduce_pixel(in_tdata);
    end
    pending = due_pixels.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives raster frames of gray pixels into the 3x3 pyramid reducer under
// several register settings and handshake idle patterns; ggr_checker predicts
// each reduced pixel and counts mismatches, tb gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import ggr_pkg::*;

  localparam int MAX_WIDTH = 2048;
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, ignored
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_PIXELS = 30;

  typedef enum int {PAT_NOISE, PAT_WHITE, PAT_BLACK, PAT_CHECKER, PAT_BINARY} pix_pattern_e;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [PIX_W-1:0]    in_tdata;    // [7:0] pixel_in
  logic                out_tvalid;
  logic                out_tready;
  logic [PIX_W-1:0]    out_tdata;   // [7:0] pixel_out
  logic                out_tlast;   // row_end
  logic                out_tuser;   // [0] frame_end
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDAT_W-1:0]   cfg_data;

  int errors, pending;

  // idle knobs, percent of cycles
  int idle_pct;
  int stall_pct;
  bit hold_stretch;   // request one long receiver hold-off

  // effective frame size after clamping, as the block sees it
  int eff_w, eff_h;

  gray_gaussian_reduce_3x3_core #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ggr_checker #(.MAX_WIDTH(MAX_WIDTH)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off counted here on request
  initial begin
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_stretch && !hold_done) begin
        hold_done  = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one pixel transfer; returns on the falling edge after it was taken
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = PIX_W'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain: every predicted pixel seen, then a wait for the two-stage pipe to
  // empty of pixels that make no result
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_size(input logic [CFGW_W-1:0] w, input logic [3:0] w_hi,
                          input logic [HGT_W-1:0] h, input logic rnd);
    settle();
    write_reg(CFG_IMAGE_WIDTH, {w_hi, w});
    write_reg(CFG_IMAGE_HEIGHT, h);
    // spare bits above the flag are don't-care
    write_reg(CFG_ROUND_ENABLE, {15'($urandom), rnd});
    eff_w = (w < MIN_WIDTH) ? MIN_WIDTH : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    eff_h = (h == 0) ? 1 : h;
  endtask

  function automatic logic [PIX_W-1:0] pixel_for(pix_pattern_e pat, int x, int y);
    case (pat)
      PAT_WHITE:   return 8'hFF;
      PAT_BLACK:   return 8'h00;
      PAT_CHECKER: return ((x ^ y) & 1) ? 8'hFF : 8'h00;
      PAT_BINARY:  return $urandom_range(1) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input pix_pattern_e pat);
    for (int y = 0; y < eff_h; y++)
      for (int x = 0; x < eff_w; x++)
        send_pixel(pixel_for(pat, x, y));
  endtask

  initial begin
    int phase_pixels;
    int pick;
    logic [CFGW_W-1:0] w;
    pix_pattern_e pat;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_IMAGE_WIDTH;
    cfg_data     = '0;
    idle_pct     = 10;
    stall_pct    = 10;
    hold_stretch = 1'b0;
    eff_w        = RST_IMAGE_WIDTH;
    eff_h        = RST_IMAGE_HEIGHT;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed ---
    // saturated input: largest sum, truncated then rounded, single row
    set_size(16, 4'h0, 1, 1'b0);
    send_frame(PAT_WHITE);
    set_size(16, 4'h0, 1, 1'b1);
    send_frame(PAT_WHITE);
    send_frame(PAT_BLACK);
    send_frame(PAT_NOISE);
    // odd width and odd height: last column and row replicate themselves
    set_size(17, 4'h0, 3, 1'b0);
    send_frame(PAT_CHECKER);
    set_size(18, 4'h0, 2, 1'b1);
    send_frame(PAT_CHECKER);
    // width under the minimum with junk above bit 11, height zero
    set_size(12'd0, 4'hF, 16'd0, 1'b1);
    send_frame(PAT_NOISE);
    settle();
    write_reg(CFG_SPARE, CDAT_W'($urandom));
    // tallest frame, then shrink both sizes mid-row: the position wraps to a
    // fresh frame on the next pixel
    set_size(24, 4'h0, 16'hFFFF, 1'b0);
    repeat (24 + 20) send_pixel(PIX_W'($urandom));
    set_size(16, 4'h0, 2, 1'b0);
    send_frame(PAT_NOISE);
    // widest row, clamped from an all-ones width; a single-row frame, so the
    // partial row wraps to a fresh frame once the width shrinks again
    idle_pct  = 0;
    stall_pct = 0;
    set_size(12'hFFF, 4'h0, 1, 1'b1);
    repeat (40) send_pixel(PIX_W'($urandom));
    set_size(16, 4'h0, 1, 1'b0);
    send_frame(PAT_NOISE);

    // --- random frames, four idle profiles ---
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 75; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      phase_pixels = 0;
      if (ph == 0) begin
        // receiver goes quiet while pixels keep coming: input must back up
        set_size(24, 4'h0, 2, 1'($urandom_range(1)));
        hold_stretch = 1'b1;
        send_frame(PAT_NOISE);
        phase_pixels += eff_w * eff_h;
      end
      while (phase_pixels < PHASE_PIXELS) begin
        pick = $urandom_range(9);
        if (pick < 8)       w = CFGW_W'($urandom_range(40, 16));
        else if (pick == 8) w = CFGW_W'($urandom_range(130, 41));
        else                w = CFGW_W'($urandom_range(15, 0));
        set_size(w, 4'($urandom), HGT_W'($urandom_range(6, 0)), 1'($urandom_range(1)));
        pat = ($urandom_range(9) < 8) ? PAT_NOISE : pix_pattern_e'($urandom_range(4, 1));
        send_frame(pat);
        phase_pixels += eff_w * eff_h;
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
